### rtl/spt_pkg.sv
package spt_pkg;

  // default table depth and coordinate width
  localparam int CAPACITY_DEFAULT   = 32;
  localparam int COORD_BITS_DEFAULT = 16;

  // widths of the fixed port fields
  localparam int FIELD_W   = 16;
  localparam int POS_W     = 5;
  localparam int DROPPED_W = 5;
  localparam int FILL_W    = 6;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_POP_FIRST = 3'd1,
    ACT_POP_LAST  = 3'd2,
    ACT_REMOVE_AT = 3'd3,
    ACT_DEDUP     = 3'd4
  } spt_action_e;

  // control of the shared squaring unit
  typedef struct packed {
    logic sq_first;  // register operand squared
    logic sq_acc;    // add operand squared to the held square
  } spt_sq_ctl_t;

endpackage

### rtl/spt_sq_unit.sv
module spt_sq_unit #(
  parameter int COORD_BITS = spt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  spt_pkg::spt_sq_ctl_t          ctl_i,
  input  logic signed [COORD_BITS-1:0]  operand_i,
  output logic [2*COORD_BITS-1:0]       dist_o
);
  import spt_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = 2 * COORD_BITS;

  logic [CW-1:0] mag;
  logic [DW-1:0] prod;
  logic [DW-1:0] sq_q, sq_d;
  logic [DW-1:0] dist_q, dist_d;

  // magnitude fits in CW unsigned bits, also for the most negative value
  assign mag  = operand_i[CW-1] ? CW'(~$unsigned(operand_i) + 1'b1) : $unsigned(operand_i);
  assign prod = DW'(mag) * DW'(mag);

  always_comb begin
    sq_d   = sq_q;
    dist_d = dist_q;
    if (ctl_i.sq_first) begin
      sq_d = prod;
    end
    if (ctl_i.sq_acc) begin
      dist_d = sq_q + prod;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    dist_q <= dist_d;
  end

  assign dist_o = dist_q;

endmodule

### rtl/spt_table_mem.sv
module spt_table_mem #(
  parameter int DEPTH = spt_pkg::CAPACITY_DEFAULT,
  parameter int WIDTH = 4 * spt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  import spt_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_point_table_by_distance_core.sv
// sequence: an insert squares x, then y, and walks down from the end; removals and
//   dedup read the start entry, then walk upward; refused or unknown actions skip to ST_FIN
// throughput: one item at a time; the table walk (one read and one write port, registered
//   read) moves one entry per cycle; a new item is taken only once the last result is handed on
// reset: entry count and handshake state clear at once; table contents stay undefined
//   until written, with no clearing pass
module sorted_point_table_by_distance_core #(
  parameter int CAPACITY   = spt_pkg::CAPACITY_DEFAULT,
  parameter int COORD_BITS = spt_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         action_i,
  input  logic signed [spt_pkg::FIELD_W-1:0] coord_x_i,
  input  logic signed [spt_pkg::FIELD_W-1:0] coord_y_i,
  input  logic [spt_pkg::POS_W-1:0]          position_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               ok_o,
  output logic signed [spt_pkg::FIELD_W-1:0] out_x_o,
  output logic signed [spt_pkg::FIELD_W-1:0] out_y_o,
  output logic [spt_pkg::DROPPED_W-1:0]      dropped_o,
  output logic [spt_pkg::FILL_W-1:0]         fill_o
);
  import spt_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int DW    = 2 * COORD_BITS;      // squared distance
  localparam int WW    = DW + 2 * COORD_BITS; // table word: {dist, x, y}
  localparam int AW    = $clog2(CAPACITY);
  localparam int CNTW  = $clog2(CAPACITY + 1);
  localparam int RAW_W = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int OW    = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int PW    = (CNTW > POS_W) ? CNTW : POS_W;
  localparam int FW    = (CNTW > FILL_W) ? CNTW : FILL_W;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,  // waiting for an input transfer
    ST_SQX  = 8'b0000_0010,  // square x of new point
    ST_SQY  = 8'b0000_0100,  // square y and sum, first read of the insert walk
    ST_INS  = 8'b0000_1000,  // walk down from the end, shifting entries up
    ST_RDF  = 8'b0001_0000,  // read the entry at the start index
    ST_LOAD = 8'b0010_0000,  // capture that entry, start walking upward
    ST_WALK = 8'b0100_0000,  // shift down (remove) or compact (dedup)
    ST_FIN  = 8'b1000_0000   // hand result to the output register
  } state_e;

  state_e state_q, state_d;

  logic [2:0]           act_q, act_d;
  logic signed [CW-1:0] nx_q, nx_d, ny_q, ny_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;     // walk position
  logic [CNTW-1:0]      w_q, w_d;         // dedup write position
  logic [CNTW-1:0]      count_q, count_d; // entries held
  logic signed [CW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic                 ok_q, ok_d;
  logic [DROPPED_W-1:0] drop_q, drop_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       out_ok_q, out_ok_d;
  logic signed [FIELD_W-1:0]  out_x_q, out_x_d, out_y_q, out_y_d;
  logic [DROPPED_W-1:0]       out_drop_q, out_drop_d;
  logic [FILL_W-1:0]          out_fill_q, out_fill_d;

  // coordinates from the low COORD_BITS bits of the fields, sign from bit COORD_BITS-1
  logic [RAW_W-1:0]     raw_x, raw_y;
  logic signed [CW-1:0] in_x, in_y;
  assign raw_x = RAW_W'($unsigned(coord_x_i));
  assign raw_y = RAW_W'($unsigned(coord_y_i));
  assign in_x  = signed'(raw_x[CW-1:0]);
  assign in_y  = signed'(raw_y[CW-1:0]);

  logic [PW-1:0] pos_ext, cnt_pos;
  assign pos_ext = PW'(position_i);
  assign cnt_pos = PW'(count_q);

  // shared squaring unit
  spt_sq_ctl_t          sq_ctl;
  logic signed [CW-1:0] sq_operand;
  logic [DW-1:0]        dist_new;

  spt_sq_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_sq (
    .clk_i     (clk_i),
    .ctl_i     (sq_ctl),
    .operand_i (sq_operand),
    .dist_o    (dist_new)
  );

  // table memory
  logic            mem_we;
  logic [CNTW-1:0] wr_sel, rd_sel;
  logic [WW-1:0]   mem_wdata, rd_word;

  spt_table_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_sel[AW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (rd_sel[AW-1:0]),
    .rdata_o (rd_word)
  );

  // fields of the entry in the read register
  logic [DW-1:0]        ent_d;
  logic signed [CW-1:0] ent_x, ent_y;
  assign ent_d = rd_word[WW-1:2*CW];
  assign ent_x = signed'(rd_word[2*CW-1:CW]);
  assign ent_y = signed'(rd_word[CW-1:0]);

  // new point sorts at or before the entry: distance, then x, then y
  logic goes_before;
  assign goes_before = (dist_new < ent_d) ||
                       ((dist_new == ent_d) &&
                        ((nx_q < ent_x) || ((nx_q == ent_x) && (ny_q <= ent_y))));

  logic is_remove;
  assign is_remove = (act_q == ACT_POP_FIRST) || (act_q == ACT_POP_LAST) ||
                     (act_q == ACT_REMOVE_AT);

  // result fields, extended to the port width
  logic signed [OW-1:0] rx_ext, ry_ext;
  logic [FW-1:0]        cnt_fill;
  assign rx_ext   = OW'(rx_q);
  assign ry_ext   = OW'(ry_q);
  assign cnt_fill = FW'(count_q);

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    w_d         = w_q;
    count_d     = count_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    ok_d        = ok_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_drop_d  = out_drop_q;
    out_fill_d  = out_fill_q;

    in_ready_o  = 1'b0;
    sq_ctl      = '0;
    sq_operand  = nx_q;
    mem_we      = 1'b0;
    wr_sel      = cnt_q;
    mem_wdata   = rd_word;
    rd_sel      = cnt_q;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d  = action_i;
          nx_d   = in_x;
          ny_d   = in_y;
          ok_d   = 1'b0;
          drop_d = '0;
          rx_d   = '0;
          ry_d   = '0;
          idx_d  = '0;
          state_d = ST_FIN;
          unique case (action_i)
            ACT_INSERT: begin
              if (count_q < CNTW'(CAPACITY)) begin
                state_d = ST_SQX;
              end
            end
            ACT_POP_FIRST, ACT_DEDUP: begin
              if (count_q != '0) begin
                state_d = ST_RDF;
              end
            end
            ACT_POP_LAST: begin
              if (count_q != '0) begin
                wr_sel  = count_q - CNTW'(1);
                idx_d   = wr_sel[AW-1:0];
                state_d = ST_RDF;
              end
            end
            ACT_REMOVE_AT: begin
              if (pos_ext < cnt_pos) begin
                idx_d   = pos_ext[AW-1:0];
                state_d = ST_RDF;
              end
            end
            default: begin
              state_d = ST_FIN;  // unknown action, nothing changes
            end
          endcase
        end
      end

      ST_SQX: begin
        sq_ctl.sq_first = 1'b1;
        sq_operand      = nx_q;
        state_d         = ST_SQY;
      end

      ST_SQY: begin
        sq_ctl.sq_acc = 1'b1;
        sq_operand    = ny_q;
        rd_sel        = count_q - CNTW'(1);  // last entry, if any
        cnt_d         = count_q;
        state_d       = ST_INS;
      end

      ST_INS: begin
        // read register holds entry cnt_q-1 when cnt_q is nonzero
        mem_we = 1'b1;
        wr_sel = cnt_q;
        rd_sel = cnt_q - CNTW'(2);
        if ((cnt_q != '0) && goes_before) begin
          mem_wdata = rd_word;
          cnt_d     = cnt_q - CNTW'(1);
        end else begin
          mem_wdata = {dist_new, nx_q, ny_q};
          count_d   = count_q + CNTW'(1);
          ok_d      = 1'b1;
          state_d   = ST_FIN;
        end
      end

      ST_RDF: begin
        rd_sel  = CNTW'(idx_q);
        state_d = ST_LOAD;
      end

      ST_LOAD: begin
        // removed point, or the kept point that dedup compares against
        rx_d    = ent_x;
        ry_d    = ent_y;
        cnt_d   = CNTW'(idx_q) + CNTW'(1);
        rd_sel  = cnt_d;
        w_d     = CNTW'(1);
        state_d = ST_WALK;
      end

      ST_WALK: begin
        rd_sel = cnt_q + CNTW'(1);
        if (cnt_q == count_q) begin
          count_d = (act_q == ACT_DEDUP) ? w_q : (count_q - CNTW'(1));
          ok_d    = 1'b1;
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + CNTW'(1);
          if (act_q == ACT_DEDUP) begin
            if ((ent_x == rx_q) && (ent_y == ry_q)) begin
              if (drop_q != '1) begin
                drop_d = drop_q + DROPPED_W'(1);
              end
            end else begin
              mem_we    = 1'b1;
              wr_sel    = w_q;
              mem_wdata = rd_word;
              rx_d      = ent_x;
              ry_d      = ent_y;
              w_d       = w_q + CNTW'(1);
            end
          end else begin
            // close the gap: entry cnt_q moves down one place
            mem_we    = 1'b1;
            wr_sel    = cnt_q - CNTW'(1);
            mem_wdata = rd_word;
          end
        end
      end

      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = ok_q;
          out_x_d     = (ok_q && is_remove) ? rx_ext[FIELD_W-1:0] : '0;
          out_y_d     = (ok_q && is_remove) ? ry_ext[FIELD_W-1:0] : '0;
          out_drop_d  = (act_q == ACT_DEDUP) ? drop_q : '0;
          out_fill_d  = (cnt_fill > FW'(63)) ? FILL_W'(63) : cnt_fill[FILL_W-1:0];
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    nx_q       <= nx_d;
    ny_q       <= ny_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    w_q        <= w_d;
    rx_q       <= rx_d;
    ry_q       <= ry_d;
    ok_q       <= ok_d;
    drop_q     <= drop_d;
    out_ok_q   <= out_ok_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_drop_q <= out_drop_d;
    out_fill_q <= out_fill_d;
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign dropped_o   = out_drop_q;
  assign fill_o      = out_fill_q;

  // table never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("entry count above capacity");

  // the table is written only by the insert walk or the remove/dedup walk
  a_write_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_INS || state_q == ST_WALK))
    else $error("table write outside a walk");

  // an input transfer always starts work on that item
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE))
    else $error("accepted item left sequencer idle");

  // a refused insert only happens on a full table
  a_insert_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && act_q == ACT_INSERT && !ok_q) |-> (count_q == CNTW'(CAPACITY)))
    else $error("insert refused with room left");

endmodule

### verif/sorted_point_table_by_distance_core_test.sv
`timescale 1ns / 1ps

module sorted_point_table_by_distance_core_test;

  localparam int W      = spt_pkg::FIELD_W;
  localparam int CAP    = spt_pkg::CAPACITY_DEFAULT;
  localparam int POS_W  = spt_pkg::POS_W;
  localparam int DROP_W = spt_pkg::DROPPED_W;
  localparam int FILL_W = spt_pkg::FILL_W;

  // action codes the block does not define
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_MID   = 3'd6;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = CAP + 20;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [W-1:0] coord_t;

  typedef struct {
    logic              ok;
    coord_t            px;
    coord_t            py;
    logic [DROP_W-1:0] dropped;
    logic [FILL_W-1:0] fill;
  } reply_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX, PH_DUPS, PH_SATURATE} phase_e;

  // table model plus queue of replies still owed by the block
  class point_table_scoreboard;
    coord_t      ent_x [CAP];
    coord_t      ent_y [CAP];
    int unsigned count;
    reply_t      pending_replies[$];
    int unsigned errors;
    int unsigned replies_seen;
    int unsigned refused_inserts;
    int unsigned full_hits;
    int unsigned max_dropped;
    int unsigned act_hist[8];

    function new();
      count           = 0;
      errors          = 0;
      replies_seen    = 0;
      refused_inserts = 0;
      full_hits       = 0;
      max_dropped     = 0;
      foreach (act_hist[k]) act_hist[k] = 0;
    endfunction

    // exact squared distance, then x, then y; equal points sort new-first
    function bit goes_before(coord_t x, coord_t y, int unsigned i);
      longint dn;
      longint de;
      dn = longint'(x) * longint'(x) + longint'(y) * longint'(y);
      de = longint'(ent_x[i]) * longint'(ent_x[i]) + longint'(ent_y[i]) * longint'(ent_y[i]);
      if (dn != de) return dn < de;
      if (x != ent_x[i]) return x < ent_x[i];
      return y <= ent_y[i];
    endfunction

    function void take_entry(int unsigned idx, ref reply_t r);
      int unsigned i;
      r.px = ent_x[idx];
      r.py = ent_y[idx];
      r.ok = 1'b1;
      for (i = idx; i + 1 < count; i++) begin
        ent_x[i] = ent_x[i + 1];
        ent_y[i] = ent_y[i + 1];
      end
      count--;
    endfunction

    function reply_t apply_action(logic [2:0] act, coord_t x, coord_t y,
                                  logic [POS_W-1:0] pos);
      reply_t      r;
      int unsigned at;
      int unsigned i;
      int unsigned w;
      int unsigned drops;
      r.ok      = 1'b0;
      r.px      = '0;
      r.py      = '0;
      r.dropped = '0;
      drops     = 0;
      case (act)
        spt_pkg::ACT_INSERT: begin
          if (count < CAP) begin
            at = count;
            for (i = 0; i < count; i++) begin
              if (goes_before(x, y, i)) begin
                at = i;
                break;
              end
            end
            for (i = count; i > at; i--) begin
              ent_x[i] = ent_x[i - 1];
              ent_y[i] = ent_y[i - 1];
            end
            ent_x[at] = x;
            ent_y[at] = y;
            count++;
            r.ok = 1'b1;
            if (count == CAP) full_hits++;
          end else begin
            refused_inserts++;
          end
        end
        spt_pkg::ACT_POP_FIRST: if (count > 0) take_entry(0, r);
        spt_pkg::ACT_POP_LAST:  if (count > 0) take_entry(count - 1, r);
        spt_pkg::ACT_REMOVE_AT: if (pos < count) take_entry(pos, r);
        spt_pkg::ACT_DEDUP: begin
          if (count > 0) begin
            w = 1;
            for (i = 1; i < count; i++) begin
              if (ent_x[i] == ent_x[w - 1] && ent_y[i] == ent_y[w - 1]) begin
                drops++;
              end else begin
                ent_x[w] = ent_x[i];
                ent_y[w] = ent_y[i];
                w++;
              end
            end
            count = w;
            r.ok  = 1'b1;
            if (drops > 31) drops = 31;
            if (drops > max_dropped) max_dropped = drops;
            r.dropped = DROP_W'(drops);
          end
        end
        default: ;
      endcase
      r.fill = FILL_W'(count > 63 ? 63 : count);
      return r;
    endfunction

    function void note_request(logic [2:0] act, coord_t x, coord_t y,
                               logic [POS_W-1:0] pos);
      act_hist[act]++;
      pending_replies.push_back(apply_action(act, x, y, pos));
    endfunction

    function void check_reply(logic ok, coord_t px, coord_t py,
                              logic [DROP_W-1:0] dropped, logic [FILL_W-1:0] fill);
      reply_t want;
      replies_seen++;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] reply %0d with nothing outstanding: %s",
                   $realtime, replies_seen,
                   $sformatf("ok=%0b x=%0d y=%0d drop=%0d fill=%0d",
                             ok, px, py, dropped, fill));
        return;
      end
      want = pending_replies.pop_front();
      if (ok !== want.ok || px !== want.px || py !== want.py ||
          dropped !== want.dropped || fill !== want.fill) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] reply %0d mismatch: exp ok=%0b x=%0d y=%0d drop=%0d fill=%0d",
                   $realtime, replies_seen, want.ok, want.px, want.py, want.dropped,
                   want.fill);
          $display("    got ok=%0b x=%0d y=%0d drop=%0d fill=%0d",
                   ok, px, py, dropped, fill);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [2:0]        action_i;
  coord_t            coord_x_i;
  coord_t            coord_y_i;
  logic [POS_W-1:0]  position_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              ok_o;
  coord_t            out_x_o;
  coord_t            out_y_o;
  logic [DROP_W-1:0] dropped_o;
  logic [FILL_W-1:0] fill_o;

  point_table_scoreboard sb = new();

  bit          hold_req   = 1'b0;
  int unsigned holds_done = 0;
  int unsigned cycle_count = 0;
  coord_t      pool_x [4];
  coord_t      pool_y [4];
  int unsigned pool_size = 1;

  sorted_point_table_by_distance_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ok_o       (ok_o),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .dropped_o  (dropped_o),
    .fill_o     (fill_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // run-length guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, sb.pending_replies.size());
      $display("FAIL sorted_point_table_by_distance_core");
      $finish;
    end
  end

  // result transfers are checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_reply(ok_o, out_x_o, out_y_o, dropped_o, fill_o);
  end

  // receiver: stretches of different stall patterns, plus long hold-offs on request
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned k;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 4);
      len  = $urandom_range(20, 120);
      for (k = 0; k < len; k++) begin
        @(negedge clk_i);
        if (hold_req) begin
          // long hold-off, counted here while the sender keeps offering
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk_i);
          hold_req = 1'b0;
          holds_done++;
        end else begin
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= 1'($urandom_range(0, 1));
            2:       out_ready_i <= ($urandom_range(0, 4) != 0);
            3:       out_ready_i <= (k % 4 == 0);
            default: out_ready_i <= (k % 10 >= 8);
          endcase
        end
      end
    end
  end

  // one input transfer; returns at the accepting edge
  task automatic send_item(logic [2:0] act, coord_t x, coord_t y, logic [POS_W-1:0] pos);
    @(negedge clk_i);
    action_i   <= act;
    coord_x_i  <= x;
    coord_y_i  <= y;
    position_i <= pos;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(act, x, y, pos);
  endtask

  task automatic idle_input(int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_replies();
    idle_input(1);
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic coord_t edge_coord(int unsigned sel);
    case (sel)
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd2;
      6:       return 16'sh7ffe;
      default: return 16'sh7fff;
    endcase
  endfunction

  function automatic void pick_point(output coord_t px, output coord_t py);
    int unsigned sel;
    int unsigned idx;
    sel = $urandom_range(0, 9);
    if (sel >= 6 && sel <= 8 && sb.count == 0) sel = 0;
    case (sel)
      0, 1, 2: begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end
      3, 4: begin
        px = coord_t'(int'($urandom_range(0, 16)) - 8);
        py = coord_t'(int'($urandom_range(0, 16)) - 8);
      end
      5: begin
        px = edge_coord($urandom_range(0, 7));
        py = edge_coord($urandom_range(0, 7));
      end
      6, 7: begin
        // exact copy of a held point
        idx = $urandom_range(0, sb.count - 1);
        px  = sb.ent_x[idx];
        py  = sb.ent_y[idx];
      end
      8: begin
        // mirrored copy, same distance, tie-break keys may differ
        idx = $urandom_range(0, sb.count - 1);
        case ($urandom_range(0, 2))
          0:       begin px = sb.ent_y[idx];  py = sb.ent_x[idx];  end
          1:       begin px = -sb.ent_x[idx]; py = sb.ent_y[idx];  end
          default: begin px = sb.ent_x[idx];  py = -sb.ent_y[idx]; end
        endcase
      end
      default: begin
        idx = $urandom_range(0, pool_size - 1);
        px  = pool_x[idx];
        py  = pool_y[idx];
      end
    endcase
  endfunction

  function automatic logic [2:0] pick_action(phase_e ph);
    int unsigned r;
    int unsigned t_ins, t_first, t_last, t_at, t_dedup;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  begin t_ins = 80; t_first = 86; t_last = 90; t_at = 95; t_dedup = 98; end
      PH_DRAIN: begin t_ins = 25; t_first = 45; t_last = 65; t_at = 88; t_dedup = 95; end
      PH_DUPS:  begin t_ins = 70; t_first = 75; t_last = 80; t_at = 88; t_dedup = 98; end
      default:  begin t_ins = 50; t_first = 60; t_last = 70; t_at = 85; t_dedup = 95; end
    endcase
    if (r < t_ins)   return spt_pkg::ACT_INSERT;
    if (r < t_first) return spt_pkg::ACT_POP_FIRST;
    if (r < t_last)  return spt_pkg::ACT_POP_LAST;
    if (r < t_at)    return spt_pkg::ACT_REMOVE_AT;
    if (r < t_dedup) return spt_pkg::ACT_DEDUP;
    return 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if (sb.count > 0 && $urandom_range(0, 9) < 7)
      return POS_W'($urandom_range(0, sb.count - 1));
    return POS_W'($urandom_range(0, 31));
  endfunction

  // main stimulus
  initial begin
    int unsigned random_sent;
    int unsigned phase_no;
    int unsigned phase_len;
    int unsigned burst_left;
    int unsigned n;
    int unsigned k;
    bit          no_gaps;
    phase_e      ph;
    logic [2:0]  act;
    coord_t      px;
    coord_t      py;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = spt_pkg::ACT_INSERT;
    coord_x_i  = '0;
    coord_y_i  = '0;
    position_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-table refusals, unknown codes, extremes, distance ties, duplicates
    send_item(spt_pkg::ACT_POP_FIRST, 16'sd3, -16'sd3, 5'd0);
    send_item(spt_pkg::ACT_POP_LAST, 16'sd0, 16'sd0, 5'd31);
    send_item(spt_pkg::ACT_REMOVE_AT, 16'sd0, 16'sd0, 5'd0);
    send_item(spt_pkg::ACT_DEDUP, 16'sd0, 16'sd0, 5'd0);
    send_item(ACT_UNUSED_FIRST, 16'sh7fff, 16'sh8000, 5'd31);
    send_item(ACT_UNUSED_LAST, 16'sh8000, 16'sh7fff, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sh7fff, 16'sh7fff, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sh8000, 16'sh8000, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd0, 16'sd0, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd5, 16'sd0, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd0, 16'sd5, 5'd0);
    send_item(spt_pkg::ACT_INSERT, -16'sd5, 16'sd0, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd3, 16'sd4, 5'd0);
    send_item(spt_pkg::ACT_INSERT, -16'sd3, -16'sd4, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd3, 16'sd4, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd3, 16'sd4, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd0, -16'sd5, 5'd0);
    send_item(spt_pkg::ACT_INSERT, 16'sd4, -16'sd3, 5'd0);
    send_item(spt_pkg::ACT_REMOVE_AT, 16'sd0, 16'sd0, 5'd31);
    send_item(spt_pkg::ACT_REMOVE_AT, 16'sd0, 16'sd0, 5'd2);
    send_item(spt_pkg::ACT_DEDUP, 16'sd0, 16'sd0, 5'd0);
    send_item(spt_pkg::ACT_POP_FIRST, 16'sd0, 16'sd0, 5'd0);
    send_item(spt_pkg::ACT_POP_LAST, 16'sd0, 16'sd0, 5'd0);
    send_item(ACT_UNUSED_MID, 16'sd1, 16'sd1, 5'd1);
    wait_for_replies();

    // random phases; each ends with the sender waiting for every reply
    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case (phase_no)
        0:       ph = PH_FILL;
        1:       ph = PH_SATURATE;
        2:       ph = PH_DRAIN;
        default: ph = phase_e'($urandom_range(0, 4));
      endcase
      pool_size = (ph == PH_SATURATE && phase_no == 1) ? 1 : $urandom_range(1, 4);
      for (k = 0; k < 4; k++) pick_point(pool_x[k], pool_y[k]);
      if (phase_no == 1 || $urandom_range(0, 4) == 0) hold_req = 1'b1;
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 20);
      phase_len  = (ph == PH_SATURATE) ? CAP + 2 : $urandom_range(30, 100);

      for (n = 0; n < phase_len; n++) begin
        if (ph == PH_SATURATE) begin
          // fill to the top from a tiny pool, at least one refused insert, then collapse
          if (n < CAP + 1) begin
            act = spt_pkg::ACT_INSERT;
            k   = $urandom_range(0, pool_size - 1);
            px  = pool_x[k];
            py  = pool_y[k];
          end else begin
            act = spt_pkg::ACT_DEDUP;
            pick_point(px, py);
          end
        end else begin
          act = pick_action(ph);
          if (ph == PH_DUPS && $urandom_range(0, 4) != 0) begin
            k  = $urandom_range(0, pool_size - 1);
            px = pool_x[k];
            py = pool_y[k];
          end else begin
            pick_point(px, py);
          end
        end
        send_item(act, px, py, pick_position());
        random_sent++;
        if (!no_gaps) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_input($urandom_range(1, 12));
            burst_left = $urandom_range(1, 20);
          end
        end
      end
      wait_for_replies();
      phase_no++;
    end

    while (hold_req) @(posedge clk_i);
    wait_for_replies();
    // keep the clock running to catch any reply nobody asked for
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d transfers in: %0d inserts (%0d refused when full), %0d/%0d/%0d %s",
             sb.replies_seen, sb.act_hist[spt_pkg::ACT_INSERT], sb.refused_inserts,
             sb.act_hist[spt_pkg::ACT_POP_FIRST], sb.act_hist[spt_pkg::ACT_POP_LAST],
             sb.act_hist[spt_pkg::ACT_REMOVE_AT], "first/last/indexed removals");
    $display("%0d collapses (most dropped %0d), table full %0d times, %0d long %s, %0d errors",
             sb.act_hist[spt_pkg::ACT_DEDUP], sb.max_dropped, sb.full_hits, holds_done,
             "output hold-offs", sb.errors);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("PASS sorted_point_table_by_distance_core");
    end else begin
      $display("FAIL sorted_point_table_by_distance_core");
    end
    $finish;
  end

endmodule
